// ----- sv/pkht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_pkg
// Shared types and constants of the pointer key hash table.
// ----------------------------------------------------------------------------
package pkht_pkg;

   localparam int BUCKETS_DEF      = 512;
   localparam int BUCKET_DEPTH_DEF = 4;
   localparam int QUEUE_DEPTH      = 2;
   localparam int KEY_BITS         = 32;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_res;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

endpackage

// ----- sv/pkht_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_front
// Accepts items, folds the key into a hash and reduces it to a bucket index
// with a reciprocal multiplication (states F_MUL and F_MOD), then pushes the
// classified item into the queue.
// ----------------------------------------------------------------------------
module pkht_front #(
   parameter int BUCKETS     = pkht_pkg::BUCKETS_DEF,
   parameter int BUCKET_BITS = $clog2(BUCKETS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               block,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pkht_pkg::req_type                  req_data,
   output logic                               push,
   output logic [$bits(pkht_pkg::req_type)+BUCKET_BITS-1:0] push_data,
   input  pkht_pkg::queue_flags_type          flags
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_MOD  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   localparam int PROD_BITS = 65;
   // ceil(2^(32+BUCKET_BITS) / BUCKETS): the quotient is exact for any 32-bit hash
   localparam logic [32:0] RECIP =
      33'(((64'd1 << (32 + BUCKET_BITS)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
   localparam logic [BUCKET_BITS-1:0] MOD_LOW = BUCKET_BITS'(BUCKETS);

   fstate_type              state_ff, state_in;
   pkht_pkg::req_type       item_ff, item_in;
   logic [31:0]             h_ff, h_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [BUCKET_BITS-1:0]  rem_ff, rem_in;
   logic [BUCKET_BITS-1:0]  q_low;
   logic [BUCKET_BITS-1:0]  qm_low;
   logic                    accept;

   assign req_stall = (state_ff != F_IDLE) || block;
   assign accept    = req_valid && !req_stall;
   assign push      = (state_ff == F_PUSH);
   assign push_data = {item_ff, rem_ff};

   // the remainder is below 2^BUCKET_BITS, so only the low bits of the quotient count
   assign q_low  = prod_ff[32 + BUCKET_BITS +: BUCKET_BITS];
   assign qm_low = q_low * MOD_LOW;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      h_in     = h_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               h_in     = req_data.key + (req_data.key >> 8) + (req_data.key >> 16)
                          + (req_data.key >> 24);
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in  = PROD_BITS'(h_ff) * PROD_BITS'(RECIP);
            state_in = F_MOD;
         end
         F_MOD: begin
            rem_in   = h_ff[BUCKET_BITS-1:0] - qm_low;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!flags.full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      h_ff    <= h_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

endmodule

// ----- sv/pkht_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module pkht_queue #(
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output pkht_pkg::queue_flags_type flags
);

   localparam int DEPTH    = pkht_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign flags.full  = (count_ff == CNT_BITS'(DEPTH));
   assign flags.empty = (count_ff == '0);
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign pop_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/pkht_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_back
// Reads one bucket row, compares all slots, writes the updated row and fill
// count back and loads the result register. Clears the fill counts after reset.
// ----------------------------------------------------------------------------
module pkht_back #(
   parameter int BUCKETS      = pkht_pkg::BUCKETS_DEF,
   parameter int BUCKET_DEPTH = pkht_pkg::BUCKET_DEPTH_DEF,
   parameter int BUCKET_BITS  = $clog2(BUCKETS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pkht_pkg::queue_flags_type flags,
   input  logic [$bits(pkht_pkg::req_type)+BUCKET_BITS-1:0] pop_data,
   output logic                      pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pkht_pkg::rsp_type         rsp_data
);

   localparam int FILL_BITS = $clog2(BUCKET_DEPTH + 1);
   localparam int ROW_BITS  = BUCKET_DEPTH * pkht_pkg::KEY_BITS;
   localparam int REQ_BITS  = $bits(pkht_pkg::req_type);

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_EXEC  = 3'b100
   } bstate_type;

   logic [FILL_BITS-1:0] fill_mem [BUCKETS];
   logic [ROW_BITS-1:0]  key_mem  [BUCKETS];
   logic [ROW_BITS-1:0]  val_mem  [BUCKETS];

   bstate_type             state_ff, state_in;
   logic [BUCKET_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   pkht_pkg::req_type      item_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [FILL_BITS-1:0]   fill_rd_ff;
   logic [ROW_BITS-1:0]    keys_rd_ff, vals_rd_ff;
   pkht_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   out_free, advance;
   logic                   hit, full;
   logic [FILL_BITS-1:0]   hit_idx;
   logic [31:0]            hit_val;
   logic [ROW_BITS-1:0]    ins_keys, ins_vals, rem_keys, rem_vals;
   logic [ROW_BITS-1:0]    new_keys, new_vals;
   logic [FILL_BITS-1:0]   new_fill;
   logic                   row_we, fill_we;
   logic [BUCKET_BITS-1:0] fill_wa;
   logic [FILL_BITS-1:0]   fill_wd;

   assign clearing  = (state_ff == B_CLEAR);
   assign pop       = (state_ff == B_IDLE) && !flags.empty;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = (state_ff == B_EXEC) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // slot compare, newest match wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      hit_val = '0;
      for (int s = 0; s < BUCKET_DEPTH; s++) begin
         if (FILL_BITS'(s) < fill_rd_ff && keys_rd_ff[s*32 +: 32] == item_ff.key) begin
            hit     = 1'b1;
            hit_idx = FILL_BITS'(s);
            hit_val = vals_rd_ff[s*32 +: 32];
         end
      end
      full = (fill_rd_ff >= FILL_BITS'(BUCKET_DEPTH));
   end

   // candidate rows for insert and remove
   always_comb begin
      ins_keys = keys_rd_ff;
      ins_vals = vals_rd_ff;
      rem_keys = keys_rd_ff;
      rem_vals = vals_rd_ff;
      for (int s = 0; s < BUCKET_DEPTH; s++) begin
         if (FILL_BITS'(s) == fill_rd_ff) begin
            ins_keys[s*32 +: 32] = item_ff.key;
            ins_vals[s*32 +: 32] = item_ff.value;
         end
      end
      for (int s = 0; s < BUCKET_DEPTH - 1; s++) begin
         if (FILL_BITS'(s) >= hit_idx) begin
            rem_keys[s*32 +: 32] = keys_rd_ff[(s+1)*32 +: 32];
            rem_vals[s*32 +: 32] = vals_rd_ff[(s+1)*32 +: 32];
         end
      end
   end

   always_comb begin
      rsp_in.status    = pkht_pkg::ST_MISS;
      rsp_in.value_res = '0;
      new_keys         = keys_rd_ff;
      new_vals         = vals_rd_ff;
      new_fill         = fill_rd_ff;
      row_we           = 1'b0;
      unique case (item_ff.operation)
         pkht_pkg::OP_LOOKUP: begin
            if (hit) begin
               rsp_in.status    = pkht_pkg::ST_DONE;
               rsp_in.value_res = hit_val;
            end
         end
         pkht_pkg::OP_INSERT: begin
            if (full) begin
               rsp_in.status = pkht_pkg::ST_FULL;
            end else begin
               rsp_in.status = pkht_pkg::ST_DONE;
               new_keys      = ins_keys;
               new_vals      = ins_vals;
               new_fill      = fill_rd_ff + 1'b1;
               row_we        = 1'b1;
            end
         end
         pkht_pkg::OP_REMOVE: begin
            if (hit) begin
               rsp_in.status    = pkht_pkg::ST_DONE;
               rsp_in.value_res = hit_val;
               new_keys         = rem_keys;
               new_vals         = rem_vals;
               new_fill         = fill_rd_ff - 1'b1;
               row_we           = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fill_we      = 1'b0;
      fill_wa      = bucket_ff;
      fill_wd      = new_fill;
      unique case (state_ff)
         B_CLEAR: begin
            fill_we    = 1'b1;
            fill_wa    = clr_cnt_ff;
            fill_wd    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BUCKET_BITS'(BUCKETS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            if (advance) begin
               fill_we      = row_we;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (pop) begin
         item_ff   <= pkht_pkg::req_type'(pop_data[REQ_BITS+BUCKET_BITS-1 -: REQ_BITS]);
         bucket_ff <= pop_data[BUCKET_BITS-1:0];
      end
   end

   // bucket memories: one read port, one write port each
   always_ff @(posedge clock) begin
      if (pop) begin
         fill_rd_ff <= fill_mem[pop_data[BUCKET_BITS-1:0]];
         keys_rd_ff <= key_mem[pop_data[BUCKET_BITS-1:0]];
         vals_rd_ff <= val_mem[pop_data[BUCKET_BITS-1:0]];
      end
      if (fill_we) begin
         fill_mem[fill_wa] <= fill_wd;
      end
      if (advance && row_we) begin
         key_mem[bucket_ff] <= new_keys;
         val_mem[bucket_ff] <= new_vals;
      end
   end

endmodule

// ----- sv/pointer_key_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_key_hash_table
// Bucketed hash table of 32-bit keys and values with lookup, insert, remove.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation item (lookup, insert or remove) with a
//   key and a value; rsp channel returns one item per request, in order, with
//   a status and the value found or removed.
//   Both channels hand over an item when valid is high and stall is low.
//   A request passes the hash, multiply and remainder registers of the front
//   end, a queue slot, the bucket row read and the result register before
//   its result is valid. The front end takes a new item only after the last
//   has gone through hash on accept, reciprocal multiply, remainder to a
//   bucket index and push into the queue. The back end also finishes each
//   item (row read, then compare and write back) before it takes the next.
//   A two-entry queue separates front and back so each stalls on its own.
//   Reset: fill counts are cleared by a pass over all BUCKETS buckets;
//   req_stall stays high during that pass.
//   When rsp_stall is held the result stays in its register; the back end
//   takes at most one more item and holds it, then the queue and front fill
//   and req_stall rises.
// ----------------------------------------------------------------------------
module pointer_key_hash_table #(
   parameter int BUCKETS      = pkht_pkg::BUCKETS_DEF,
   parameter int BUCKET_DEPTH = pkht_pkg::BUCKET_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pkht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pkht_pkg::rsp_type rsp_data
);

   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int ITEM_BITS   = $bits(pkht_pkg::req_type) + BUCKET_BITS;

   logic                      push, pop, clearing;
   logic [ITEM_BITS-1:0]      push_data, pop_data;
   pkht_pkg::queue_flags_type flags;

   pkht_front #(
      .BUCKETS     (BUCKETS),
      .BUCKET_BITS (BUCKET_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .block     (clearing),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .flags     (flags)
   );

   pkht_queue #(
      .WIDTH (ITEM_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .flags     (flags)
   );

   pkht_back #(
      .BUCKETS      (BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH),
      .BUCKET_BITS  (BUCKET_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .flags     (flags),
      .pop_data  (pop_data),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/pkht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module pkht_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pkht_pkg::rsp_type rsp_data
);

   logic [3:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 4'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pkht_pkg::ST_DONE |-> rsp_data.value_res == 32'd0)
      else $error("miss or full result carries a nonzero value");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall && !rsp_valid)
      else $error("request taken during the clearing pass");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result item without an accepted request");

endmodule

bind pointer_key_hash_table pkht_checker u_pkht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pointer key hash table. A shadow copy of the
// buckets predicts status and value for every accepted request. Each result
// is checked in order against the oldest prediction. Random traffic is built
// around a small pool of colliding keys so that buckets fill up, shadow older
// entries and drain again. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int         SLOTS       = pkht_pkg::BUCKETS_DEF * pkht_pkg::BUCKET_DEPTH_DEF;
   localparam logic [1:0] OP_SPARE    = 2'd3;
   localparam int         POOL_BKTS   = 8;
   localparam int         POOL_SIZE   = POOL_BKTS * 3;
   localparam int         LONG_HOLD   = 300;
   localparam int         TAIL_CYCLES = 40;

   // Shadow of the bucket store: predicts one result per request.
   class hash_shadow;
      int unsigned       fill [pkht_pkg::BUCKETS_DEF];
      bit [31:0]         slot_key [SLOTS];
      bit [31:0]         slot_value [SLOTS];
      pkht_pkg::rsp_type awaited [$];
      int                errors;

      function new();
         errors = 0;
         foreach (fill[i]) fill[i] = 0;
      endfunction

      static function int unsigned bucket_index(bit [31:0] k);
         bit [31:0] h;
         h = k + (k >> 8) + (k >> 16) + (k >> 24);
         return h % pkht_pkg::BUCKETS_DEF;
      endfunction

      function int newest_match(int unsigned b, bit [31:0] k);
         int s;
         for (s = int'(fill[b]) - 1; s >= 0; s--) begin
            if (slot_key[b * pkht_pkg::BUCKET_DEPTH_DEF + s] == k) return s;
         end
         return -1;
      endfunction

      function void note_request(pkht_pkg::req_type item);
         pkht_pkg::rsp_type e;
         int unsigned       b;
         int unsigned       base;
         int                s;
         int                f;
         int                i;
         e.status    = pkht_pkg::ST_MISS;
         e.value_res = '0;
         b    = bucket_index(item.key);
         base = b * pkht_pkg::BUCKET_DEPTH_DEF;
         f    = fill[b];
         case (item.operation)
            pkht_pkg::OP_LOOKUP: begin
               s = newest_match(b, item.key);
               if (s >= 0) begin
                  e.status    = pkht_pkg::ST_DONE;
                  e.value_res = slot_value[base + s];
               end
            end
            pkht_pkg::OP_INSERT: begin
               if (f >= pkht_pkg::BUCKET_DEPTH_DEF) begin
                  e.status = pkht_pkg::ST_FULL;
               end else begin
                  slot_key[base + f]   = item.key;
                  slot_value[base + f] = item.value;
                  fill[b]              = f + 1;
                  e.status             = pkht_pkg::ST_DONE;
               end
            end
            pkht_pkg::OP_REMOVE: begin
               s = newest_match(b, item.key);
               if (s >= 0) begin
                  e.status    = pkht_pkg::ST_DONE;
                  e.value_res = slot_value[base + s];
                  // close the gap: newer entries move down one slot
                  for (i = s; i + 1 < f; i++) begin
                     slot_key[base + i]   = slot_key[base + i + 1];
                     slot_value[base + i] = slot_value[base + i + 1];
                  end
                  fill[b] = f - 1;
               end
            end
            default: ;
         endcase
         awaited.push_back(e);
      endfunction

      function void check_result(pkht_pkg::rsp_type got);
         pkht_pkg::rsp_type e;
         if (awaited.size() == 0) begin
            $error("result with nothing outstanding: status=%0d value_res=%h",
                   got.status, got.value_res);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            errors++;
         end
         if (got.value_res !== e.value_res) begin
            $error("value_res: expected %h, actual %h", e.value_res, got.value_res);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   pkht_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   pkht_pkg::rsp_type rsp_data;

   hash_shadow shadow = new();

   bit [31:0] key_pool [POOL_SIZE];
   int        idle_level;
   int        insert_pct;
   bit        long_hold_req;

   pointer_key_hash_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(99);
      if (idle_level == 0) return 0;
      if (idle_level == 1) begin
         if (pick < 65) return 0;
         if (pick < 93) return $urandom_range(3, 1);
         return $urandom_range(40, 8);
      end
      if (pick < 30) return 0;
      if (pick < 80) return $urandom_range(6, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic bit [31:0] key_in_bucket(int unsigned b, bit [31:0] avoid);
      bit [31:0] k;
      do k = $urandom; while (hash_shadow::bucket_index(k) != b || k == avoid);
      return k;
   endfunction

   function automatic pkht_pkg::req_type make_req(logic [1:0] op, logic [31:0] k,
                                                  logic [31:0] v);
      pkht_pkg::req_type r;
      r.operation = op;
      r.key       = k;
      r.value     = v;
      return r;
   endfunction

   function automatic pkht_pkg::req_type random_item();
      pkht_pkg::req_type r;
      int                pick;
      pick  = $urandom_range(99);
      r.key = (pick < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      pick  = $urandom_range(99);
      if (pick < 4)      r.value = '0;
      else if (pick < 8) r.value = '1;
      else               r.value = $urandom;
      pick = $urandom_range(99);
      if (pick < insert_pct)                              r.operation = pkht_pkg::OP_INSERT;
      else if (pick < insert_pct + (96 - insert_pct) / 2) r.operation = pkht_pkg::OP_LOOKUP;
      else if (pick < 96)                                 r.operation = pkht_pkg::OP_REMOVE;
      else                                                r.operation = OP_SPARE;
      return r;
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input pkht_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      shadow.note_request(item);
      @(negedge clock);
   endtask

   task automatic pause_req(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_random(input int count);
      repeat (count) begin
         send_item(random_item());
         pause_req(gap_cycles());
      end
   endtask

   task automatic wait_drained();
      while (shadow.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic send_directed();
      bit [31:0]         col;
      pkht_pkg::req_type seq [$];
      col = key_in_bucket(0, 32'h0);
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, 32'h0, 32'hFFFF_FFFF));
      seq.push_back(make_req(pkht_pkg::OP_INSERT, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF));
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678));
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0));
      seq.push_back(make_req(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      seq.push_back(make_req(pkht_pkg::OP_INSERT, col, 32'h0BAD_F00D));
      seq.push_back(make_req(pkht_pkg::OP_INSERT, 32'h0, 32'hA5A5_A5A5));
      // bucket now full: refuse both the same key and a colliding one
      seq.push_back(make_req(pkht_pkg::OP_INSERT, 32'h0, 32'h5A5A_5A5A));
      seq.push_back(make_req(pkht_pkg::OP_INSERT, col, 32'h1));
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, col, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, 32'h0, 32'h0));
      // middle entry goes, the colliding key shifts down
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, col, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, col, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_LOOKUP, col, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, 32'h0, 32'h0));
      seq.push_back(make_req(pkht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0));
      seq.push_back(make_req(OP_SPARE, 32'h0, 32'h0));
      foreach (seq[i]) begin
         send_item(seq[i]);
         pause_req(gap_cycles());
      end
   endtask

   // Result side: random stall pattern, plus one long hold on request.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            n = gap_cycles();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            shadow.check_result(rsp_data);
      end
   end

   initial begin
      int unsigned b;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      idle_level    = 1;
      insert_pct    = 45;
      long_hold_req = 1'b0;
      for (int i = 0; i < POOL_BKTS; i++) begin
         b = (i == 0) ? 0 : $urandom_range(pkht_pkg::BUCKETS_DEF - 1);
         for (int j = 0; j < 3; j++) key_pool[i * 3 + j] = key_in_bucket(b, 32'h0);
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_directed();
      send_random(500);

      // hold the result side while the sender keeps pushing
      idle_level    = 0;
      long_hold_req = 1'b1;
      send_random(60);
      pause_req(1);
      wait_drained();

      insert_pct = 60;
      send_random(500);

      idle_level = 2;
      insert_pct = 20;
      send_random(480);

      idle_level = 1;
      insert_pct = 45;
      send_random(460);
      pause_req(1);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (shadow.errors == 0 && shadow.awaited.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
